// File: design/folding_time_histogram_defines.svh
// Assertion macros used by the folding time histogram top level.
`ifndef FOLDING_TIME_HISTOGRAM_DEFINES_SVH
`define FOLDING_TIME_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while arst_n is low.
`define FTH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle while arst_n is low.
`define FTH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/fth_pkg.sv
// Types, constants and codes shared by the folding time histogram modules.
package fth_pkg;

	localparam int NUM_BINS = 1024;
	localparam int VALUE_FRAC_BITS = 16;
	localparam int IDX_W = $clog2(NUM_BINS);
	localparam int HALF_BINS = NUM_BINS / 2;
	localparam int VAL_W = 48;
	localparam int FIELD_IDX_W = 10;
	localparam int CFG_DATA_W = 23;
	localparam int CFG_IDX_W = 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_Q_W = 48;
	localparam int DIV_D_W = 64;
	localparam int DIV_N_W = 64 + VALUE_FRAC_BITS;
	localparam int RES_W = DIV_Q_W + 1;
	localparam logic [31:0] RESET_WIDTH = 32'd1024;

	localparam logic KIND_READ = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 1'd1;

	typedef enum logic [1:0] {
		ST_ADDED    = 2'd0,
		ST_DISABLED = 2'd1,
		ST_BAD      = 2'd2,
		ST_READ     = 2'd3
	} status_t;

	typedef struct packed {
		logic               kind;
		logic [31:0]        start_time;
		logic [31:0]        end_time;
		logic signed [31:0] sample_value;
		logic [9:0]         read_index;
	} in_word_t;

	typedef struct packed {
		status_t            status;
		logic [9:0]         start_bin;
		logic [9:0]         bin_span;
		logic [5:0]         fold_count;
		logic [31:0]        bucket_width_now;
		logic signed [47:0] bin_value;
		logic               bin_valid;
		logic [9:0]         last_filled_bin;
	} out_word_t;

	typedef struct packed {
		logic               is_read;
		logic               bad;
		logic [31:0]        top;
		logic [31:0]        start_time;
		logic [31:0]        end_time;
		logic signed [31:0] sample_value;
		logic [9:0]         read_index;
	} cmd_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] num;
		logic [DIV_D_W-1:0] den;
		logic               neg;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [RES_W-1:0] res;
	} div_rsp_t;

	typedef struct packed {
		logic                    valid;
		logic signed [VAL_W-1:0] val;
	} bin_t;

	typedef enum logic [4:0] {
		B_SWEEP,
		B_IDLE,
		B_READ_WAIT,
		B_FOLD_TEST,
		B_FOLD_WALK,
		B_FOLD_CLR,
		B_DIV_LAST,
		B_DIV_FIRST,
		B_MUL_A,
		B_MUL_B,
		B_MUL_C,
		B_DIV_MID,
		B_DIV_AFIRST,
		B_DIV_ALAST,
		B_DIV_SINGLE,
		B_ADD_RD,
		B_ADD_WR,
		B_DONE
	} back_state_t;

	typedef enum logic [1:0] {
		PH_SINGLE,
		PH_FIRST,
		PH_LAST,
		PH_MID
	} add_phase_t;

endpackage

// File: design/fth_front.sv
// Input stage: accepts words, classifies them and hands them to the queue.
module fth_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  fth_pkg::in_word_t in_data,
	input  logic             hold,
	output logic             push_valid,
	input  logic             push_ready,
	output fth_pkg::cmd_t    push_cmd
);
	import fth_pkg::*;

	logic v_s1;
	cmd_t cmd_s1;

	assign in_ready = !hold && (!v_s1 || push_ready);
	assign push_valid = v_s1;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1.is_read <= (in_data.kind == KIND_READ);
			cmd_s1.bad <= (in_data.end_time < in_data.start_time);
			cmd_s1.top <= (in_data.start_time > in_data.end_time) ?
				in_data.start_time : in_data.end_time;
			cmd_s1.start_time <= in_data.start_time;
			cmd_s1.end_time <= in_data.end_time;
			cmd_s1.sample_value <= in_data.sample_value;
			cmd_s1.read_index <= in_data.read_index;
		end
	end

endmodule

// File: design/fth_queue.sv
// Short command queue between the input stage and the bin engine.
module fth_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  fth_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output fth_pkg::cmd_t pop_cmd
);
	import fth_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: design/fth_divider.sv
// Radix-2 restoring divider giving a signed floor quotient, one bit per cycle.
module fth_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  fth_pkg::div_req_t req,
	output fth_pkg::div_rsp_t rsp
);
	import fth_pkg::*;

	localparam int CNT_W = $clog2(DIV_Q_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] den_q;
	logic [DIV_Q_W-1:0] num_q;
	logic [DIV_Q_W-1:0] quo_q;
	logic               neg_q;
	logic [DIV_D_W:0]   trial;
	logic               fits;
	logic signed [RES_W-1:0] mag;

	assign trial = {rem_q, num_q[DIV_Q_W-1]};
	assign fits = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DIV_D_W'(req.num[DIV_N_W-1:DIV_Q_W]);
			num_q <= req.num[DIV_Q_W-1:0];
			den_q <= req.den;
			neg_q <= req.neg;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_D_W'(trial - {1'b0, den_q}) : trial[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_Q_W-2:0], fits};
			num_q <= {num_q[DIV_Q_W-2:0], 1'b0};
		end
	end

	always_comb begin
		mag = $signed({1'b0, quo_q});
		rsp.done = done_q;
		if (neg_q) begin
			rsp.res = -mag - ((rem_q != '0) ? RES_W'(1) : RES_W'(0));
		end else begin
			rsp.res = mag;
		end
	end

endmodule

// File: design/fth_back.sv
// Bin engine: folds the bin memory, spreads added values and serves reads.
module fth_back (
	input  logic              clk,
	input  logic              arst_n,
	input  fth_pkg::cfg_t     cfg,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  fth_pkg::cmd_t     pop_cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output fth_pkg::out_word_t out_data,
	output logic              sweep_busy,
	output fth_pkg::div_req_t div_req,
	input  fth_pkg::div_rsp_t div_rsp
);
	import fth_pkg::*;

	localparam int PTR_W = IDX_W + 1;

	back_state_t state_q;
	back_state_t state_d;

	bin_t mem [NUM_BINS];
	bin_t rd_a_q;
	bin_t rd_b_q;
	logic [IDX_W-1:0] rd_a_addr;
	logic [IDX_W-1:0] rd_b_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	bin_t             wr_data;

	cmd_t              cmd_q;
	logic [31:0]       width_q;
	logic              enabled_q;
	logic [IDX_W-1:0]  mark_q;
	logic [5:0]        folds_q;
	logic [IDX_W-1:0]  first_q;
	logic [IDX_W-1:0]  last_q;
	status_t           status_q;
	logic [PTR_W-1:0]  ptr_q;
	logic              found_q;
	logic [IDX_W-1:0]  fmark_q;
	logic              fw_s1;
	logic [IDX_W-1:0]  fj_s1;
	logic [63:0]       p1_q;
	logic [63:0]       p2_q;
	logic [63:0]       d_q;
	logic [31:0]       tfirst_q;
	logic [31:0]       tlast_q;
	logic [63:0]       m1_q;
	logic [63:0]       m2_q;
	logic signed [RES_W-1:0] mid_q;
	logic signed [RES_W-1:0] amt_first_q;
	logic signed [RES_W-1:0] amt_last_q;
	logic signed [RES_W-1:0] add_amt_q;
	logic [IDX_W-1:0]  add_addr_q;
	add_phase_t        phase_q;
	bin_t              rdbin_q;
	logic              out_valid_q;
	out_word_t         out_q;

	logic        need_fold;
	logic [31:0] vabs;
	logic        vneg;
	logic        out_free;
	logic        read_in_range;
	logic [IDX_W-1:0] res_idx;
	out_word_t   res_word;

	function automatic bin_t merge_pair(bin_t e, bin_t o);
		logic signed [VAL_W:0] s;
		bin_t r;
		s = {e.val[VAL_W-1], e.val} + {o.val[VAL_W-1], o.val};
		r.valid = e.valid;
		if (e.valid && o.valid) begin
			r.val = s[VAL_W:1];
		end else if (e.valid) begin
			r.val = e.val >>> 1;
		end else begin
			r.val = '0;
		end
		return r;
	endfunction

	function automatic bin_t sat_add(bin_t b, logic signed [RES_W-1:0] amt);
		logic signed [VAL_W+1:0] s;
		logic signed [VAL_W+1:0] base;
		logic signed [VAL_W+1:0] hi;
		logic signed [VAL_W+1:0] lo;
		bin_t r;
		hi = {3'b000, {(VAL_W-1){1'b1}}};
		lo = {3'b111, {(VAL_W-1){1'b0}}};
		base = b.valid ? {{2{b.val[VAL_W-1]}}, b.val} : '0;
		s = base + {amt[RES_W-1], amt};
		r.valid = 1'b1;
		if (s > hi) begin
			r.val = hi[VAL_W-1:0];
		end else if (s < lo) begin
			r.val = lo[VAL_W-1:0];
		end else begin
			r.val = s[VAL_W-1:0];
		end
		return r;
	endfunction

	assign need_fold = ((64'(width_q) << IDX_W) <= 64'(cmd_q.top));
	assign vneg = cmd_q.sample_value[31];
	assign vabs = vneg ? 32'(-cmd_q.sample_value) : cmd_q.sample_value;
	assign out_free = !out_valid_q || out_ready;
	assign read_in_range = (32'(cmd_q.read_index) < 32'(NUM_BINS));
	assign res_idx = div_rsp.res[IDX_W-1:0];
	assign sweep_busy = (state_q == B_SWEEP);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		res_word.status = status_q;
		res_word.start_bin = (status_q == ST_ADDED) ? FIELD_IDX_W'(first_q) : '0;
		res_word.bin_span = (status_q == ST_ADDED) ? FIELD_IDX_W'(last_q - first_q) : '0;
		res_word.fold_count = folds_q;
		res_word.bucket_width_now = width_q;
		res_word.bin_valid = (status_q == ST_READ) && rdbin_q.valid;
		res_word.bin_value = res_word.bin_valid ? rdbin_q.val : '0;
		res_word.last_filled_bin = FIELD_IDX_W'(mark_q);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[rd_a_addr];
		rd_b_q <= mem[rd_b_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_SWEEP: begin
				if (ptr_q == PTR_W'(NUM_BINS - 1)) state_d = B_IDLE;
			end
			B_IDLE: begin
				if (pop_valid) state_d = pop_cmd.is_read ? B_READ_WAIT : B_FOLD_TEST;
			end
			B_READ_WAIT: state_d = B_DONE;
			B_FOLD_TEST: state_d = need_fold ? B_FOLD_WALK : B_DIV_LAST;
			B_FOLD_WALK: begin
				if (ptr_q == PTR_W'(HALF_BINS) && !fw_s1) state_d = B_FOLD_CLR;
			end
			B_FOLD_CLR: begin
				if (ptr_q == PTR_W'(NUM_BINS - 1)) state_d = B_FOLD_TEST;
			end
			B_DIV_LAST: begin
				if (div_rsp.done) begin
					state_d = (!enabled_q || cmd_q.bad) ? B_DONE : B_DIV_FIRST;
				end
			end
			B_DIV_FIRST: begin
				if (div_rsp.done) state_d = (res_idx == last_q) ? B_DIV_SINGLE : B_MUL_A;
			end
			B_MUL_A: state_d = B_MUL_B;
			B_MUL_B: state_d = B_MUL_C;
			B_MUL_C: state_d = B_DIV_MID;
			B_DIV_MID: if (div_rsp.done) state_d = B_DIV_AFIRST;
			B_DIV_AFIRST: if (div_rsp.done) state_d = B_DIV_ALAST;
			B_DIV_ALAST: if (div_rsp.done) state_d = B_ADD_RD;
			B_DIV_SINGLE: if (div_rsp.done) state_d = B_ADD_RD;
			B_ADD_RD: state_d = B_ADD_WR;
			B_ADD_WR: begin
				case (phase_q)
					PH_SINGLE: state_d = B_DONE;
					PH_FIRST: state_d = B_ADD_RD;
					PH_LAST: state_d = (IDX_W'(first_q + 1'b1) != last_q) ? B_ADD_RD : B_DONE;
					default: state_d = (IDX_W'(add_addr_q + 1'b1) != last_q) ? B_ADD_RD : B_DONE;
				endcase
			end
			B_DONE: if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop_ready = 1'b0;
		rd_a_addr = add_addr_q;
		rd_b_addr = add_addr_q;
		wr_en = 1'b0;
		wr_addr = ptr_q[IDX_W-1:0];
		wr_data = '0;
		div_req.start = 1'b0;
		div_req.num = DIV_N_W'(cmd_q.end_time);
		div_req.den = DIV_D_W'(width_q);
		div_req.neg = 1'b0;
		unique case (state_q)
			B_SWEEP, B_FOLD_CLR: begin
				wr_en = 1'b1;
			end
			B_IDLE: begin
				pop_ready = 1'b1;
				rd_a_addr = IDX_W'(pop_cmd.read_index);
			end
			B_FOLD_TEST: begin
				div_req.start = !need_fold;
			end
			B_FOLD_WALK: begin
				rd_a_addr = IDX_W'({ptr_q, 1'b0});
				rd_b_addr = IDX_W'({ptr_q, 1'b1});
				wr_en = fw_s1;
				wr_addr = fj_s1;
				wr_data = merge_pair(rd_a_q, rd_b_q);
			end
			B_DIV_LAST: begin
				div_req.start = div_rsp.done && enabled_q && !cmd_q.bad;
				div_req.num = DIV_N_W'(cmd_q.start_time);
			end
			B_DIV_FIRST: begin
				div_req.start = div_rsp.done && (res_idx == last_q);
				div_req.num = DIV_N_W'(vabs) << VALUE_FRAC_BITS;
				div_req.neg = vneg;
			end
			B_MUL_C: begin
				div_req.start = 1'b1;
				div_req.num = DIV_N_W'(vabs) << VALUE_FRAC_BITS;
				div_req.den = DIV_D_W'(cmd_q.end_time - cmd_q.start_time);
				div_req.neg = vneg;
			end
			B_DIV_MID: begin
				div_req.start = div_rsp.done;
				div_req.num = DIV_N_W'(m1_q) << VALUE_FRAC_BITS;
				div_req.den = d_q;
				div_req.neg = vneg;
			end
			B_DIV_AFIRST: begin
				div_req.start = div_rsp.done;
				div_req.num = DIV_N_W'(m2_q) << VALUE_FRAC_BITS;
				div_req.den = d_q;
				div_req.neg = vneg;
			end
			B_ADD_WR: begin
				wr_en = 1'b1;
				wr_addr = add_addr_q;
				wr_data = sat_add(rd_a_q, add_amt_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			width_q <= RESET_WIDTH;
			enabled_q <= 1'b1;
			mark_q <= '0;
			out_valid_q <= 1'b0;
			fw_s1 <= 1'b0;
		end else begin
			if (state_q == B_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_SWEEP, B_FOLD_CLR: begin
					ptr_q <= ptr_q + 1'b1;
				end
				B_FOLD_TEST: begin
					if (need_fold) begin
						width_q <= width_q << 1;
						ptr_q <= '0;
						fw_s1 <= 1'b0;
					end
				end
				B_FOLD_WALK: begin
					fw_s1 <= (ptr_q < PTR_W'(HALF_BINS));
					if (ptr_q < PTR_W'(HALF_BINS)) begin
						ptr_q <= ptr_q + 1'b1;
					end else if (!fw_s1) begin
						mark_q <= found_q ? fmark_q : IDX_W'(HALF_BINS - 1);
					end
				end
				B_DIV_LAST: begin
					if (div_rsp.done) mark_q <= res_idx;
				end
				default: begin
				end
			endcase
			if (cfg.we) begin
				if (cfg.index == CFG_INIT_WIDTH) begin
					width_q <= (cfg.data == '0) ? 32'd1 : 32'(cfg.data);
				end else if (cfg.index == CFG_ENABLED) begin
					enabled_q <= cfg.data[0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				cmd_q <= pop_cmd;
				folds_q <= '0;
			end
			B_READ_WAIT: begin
				status_q <= ST_READ;
				rdbin_q.valid <= read_in_range && rd_a_q.valid;
				rdbin_q.val <= rd_a_q.val;
			end
			B_FOLD_TEST: begin
				if (need_fold) begin
					folds_q <= folds_q + 1'b1;
					found_q <= 1'b0;
				end
			end
			B_FOLD_WALK: begin
				fj_s1 <= ptr_q[IDX_W-1:0];
				if (fw_s1 && !rd_b_q.valid && !found_q) begin
					found_q <= 1'b1;
					fmark_q <= fj_s1;
				end
			end
			B_DIV_LAST: begin
				if (div_rsp.done) begin
					last_q <= res_idx;
					if (!enabled_q) begin
						status_q <= ST_DISABLED;
					end else if (cmd_q.bad) begin
						status_q <= ST_BAD;
					end else begin
						status_q <= ST_ADDED;
					end
				end
			end
			B_DIV_FIRST: begin
				if (div_rsp.done) first_q <= res_idx;
			end
			B_MUL_A: begin
				p1_q <= 64'(32'(first_q) + 32'd1) * 64'(width_q);
				p2_q <= 64'(last_q) * 64'(width_q);
				d_q <= 64'(cmd_q.end_time - cmd_q.start_time) * 64'(width_q);
			end
			B_MUL_B: begin
				tfirst_q <= 32'(p1_q - 64'(cmd_q.start_time));
				tlast_q <= 32'(64'(cmd_q.end_time) - p2_q);
			end
			B_MUL_C: begin
				m1_q <= 64'(vabs) * 64'(tfirst_q);
				m2_q <= 64'(vabs) * 64'(tlast_q);
			end
			B_DIV_MID: begin
				if (div_rsp.done) mid_q <= div_rsp.res;
			end
			B_DIV_AFIRST: begin
				if (div_rsp.done) amt_first_q <= div_rsp.res;
			end
			B_DIV_ALAST: begin
				if (div_rsp.done) begin
					amt_last_q <= div_rsp.res;
					add_addr_q <= first_q;
					add_amt_q <= amt_first_q;
					phase_q <= PH_FIRST;
				end
			end
			B_DIV_SINGLE: begin
				if (div_rsp.done) begin
					add_addr_q <= first_q;
					add_amt_q <= div_rsp.res;
					phase_q <= PH_SINGLE;
				end
			end
			B_ADD_WR: begin
				case (phase_q)
					PH_FIRST: begin
						add_addr_q <= last_q;
						add_amt_q <= amt_last_q;
						phase_q <= PH_LAST;
					end
					PH_LAST: begin
						add_addr_q <= IDX_W'(first_q + 1'b1);
						add_amt_q <= mid_q;
						phase_q <= PH_MID;
					end
					default: begin
						add_addr_q <= IDX_W'(add_addr_q + 1'b1);
					end
				endcase
			end
			B_DONE: begin
				if (out_free) out_q <= res_word;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: design/folding_time_histogram.sv
// Top level of the folding time histogram: input stage, queue, bin engine, divider.
// After reset the block sweeps its 1024-entry bin memory and takes no word during that
// sweep. Words are then handled one at a time by the bin engine, whose divisions run on a
// one-bit-per-cycle divider of 48 steps: an add that is disabled or bad stops after one
// division, an add inside one bin needs two more, and an add that spans bins needs four
// more and then writes its first, last and middle bins. Each fold walks the memory pairwise
// through two read ports and then clears the upper half. A two-entry queue lets the input
// side keep accepting while the engine works, and an output register holds a finished word
// until it is taken.
module folding_time_histogram (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [fth_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fth_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  fth_pkg::in_word_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output fth_pkg::out_word_t                   out_data
);
	import fth_pkg::*;

	`include "folding_time_histogram_defines.svh"

	cfg_t     cfg;
	logic     push_valid;
	logic     push_ready;
	cmd_t     push_cmd;
	logic     pop_valid;
	logic     pop_ready;
	cmd_t     pop_cmd;
	logic     sweep_busy;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign cfg.we = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data = cfg_data;

	fth_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.hold       (sweep_busy),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	fth_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	fth_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fth_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.sweep_busy (sweep_busy),
		.div_req    (div_req),
		.div_rsp    (div_rsp)
	);

	`FTH_ASSERT_NOW(a_read_no_fold, out_valid && out_data.status == ST_READ, out_data.fold_count == 6'd0 && out_data.bin_span == 10'd0, "read word carries fold or span data")
	`FTH_ASSERT_NOW(a_bin_valid_only_read, out_valid && out_data.status != ST_READ, !out_data.bin_valid && out_data.bin_value == 48'sd0, "bin data on a non-read word")
	`FTH_ASSERT_NOW(a_width_nonzero, out_valid, out_data.bucket_width_now != 32'd0, "bucket width reported as zero")
	`FTH_ASSERT_NEXT(a_sweep_no_result, sweep_busy, !out_valid, "result word during memory sweep")

endmodule

// File: sim/folding_time_histogram_tb.sv
// Self-checking testbench for the folding time histogram with its own bin predictor.
module folding_time_histogram_tb;
	import fth_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	in_word_t in_data;
	logic out_valid;
	logic out_ready;
	out_word_t out_data;

	folding_time_histogram DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	localparam longint VMAX = (64'sd1 <<< 47) - 1;
	localparam longint VMIN = -VMAX - 1;

	longint bin_val [NUM_BINS];
	bit bin_ok [NUM_BINS];
	longint unsigned cur_width;
	int unsigned cur_mark;
	bit add_enabled;

	out_word_t pending_words[$];
	int fails;
	bit send_idle;
	bit take_idle;
	int stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic longint halve_floor(longint x);
		return x >>> 1;
	endfunction

	function automatic longint frac_div(longint a, longint unsigned d);
		longint unsigned m, q, r;
		longint res;
		m = (a < 0) ? longint'(0) - a : a;
		q = m / d;
		r = m % d;
		for (int i = 0; i < VALUE_FRAC_BITS; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 1;
			end
		end
		res = longint'(q);
		if (a < 0) begin
			res = -res;
			if (r != 0)
				res = res - 1;
		end
		return res;
	endfunction

	function automatic void bin_gain(int unsigned idx, longint amt);
		longint s;
		s = (bin_ok[idx] ? bin_val[idx] : 0) + amt;
		if (s > VMAX) s = VMAX;
		if (s < VMIN) s = VMIN;
		bin_val[idx] = s;
		bin_ok[idx] = 1'b1;
	endfunction

	function automatic void fold_bins();
		bit found;
		int unsigned m;
		longint ev, ov;
		bit eok, ook;
		found = 0;
		m = HALF_BINS - 1;
		cur_width = cur_width * 2;
		for (int j = 0; j < HALF_BINS; j++) begin
			ev = bin_val[2*j];
			ov = bin_val[2*j+1];
			eok = bin_ok[2*j];
			ook = bin_ok[2*j+1];
			if (eok && ook) bin_val[j] = halve_floor(ev + ov);
			else if (eok) bin_val[j] = halve_floor(ev);
			else bin_val[j] = 0;
			bin_ok[j] = eok;
			if (!ook && !found) begin
				found = 1;
				m = j;
			end
		end
		cur_mark = m;
		for (int k = HALF_BINS; k < NUM_BINS; k++) begin
			bin_val[k] = 0;
			bin_ok[k] = 0;
		end
	endfunction

	function automatic out_word_t histogram_outcome(in_word_t w);
		out_word_t o;
		longint unsigned st, en, top, elapsed, tf, tl, d;
		longint v, mid;
		int unsigned first, last, folds;
		o = '0;
		st = w.start_time;
		en = w.end_time;
		v = w.sample_value;
		folds = 0;
		if (w.kind == KIND_READ) begin
			o.status = ST_READ;
			if (bin_ok[w.read_index]) begin
				o.bin_value = bin_val[w.read_index];
				o.bin_valid = 1'b1;
			end
		end else begin
			top = (st > en) ? st : en;
			while (cur_width * NUM_BINS <= top) begin
				fold_bins();
				folds++;
			end
			cur_mark = en / cur_width;
			if (!add_enabled) begin
				o.status = ST_DISABLED;
			end else if (en < st) begin
				o.status = ST_BAD;
			end else begin
				first = st / cur_width;
				last = en / cur_width;
				if (first == last) begin
					bin_gain(first, frac_div(v, cur_width));
				end else begin
					elapsed = en - st;
					tf = (longint'(first) + 1) * cur_width - st;
					tl = en - longint'(last) * cur_width;
					d = elapsed * cur_width;
					mid = frac_div(v, elapsed);
					bin_gain(first, frac_div(v * longint'(tf), d));
					bin_gain(last, frac_div(v * longint'(tl), d));
					for (int unsigned i = first + 1; i < last; i++)
						bin_gain(i, mid);
				end
				o.status = ST_ADDED;
				o.start_bin = first;
				o.bin_span = last - first;
			end
		end
		o.fold_count = folds;
		o.bucket_width_now = cur_width[31:0];
		o.last_filled_bin = cur_mark[9:0];
		return o;
	endfunction

	task automatic send_word(in_word_t w);
		int gap;
		gap = send_idle ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_words.push_back(histogram_outcome(w));
	endtask

	task automatic send_add(longint unsigned st, longint unsigned en, int v);
		in_word_t w;
		w = '0;
		w.start_time = st;
		w.end_time = en;
		w.sample_value = v;
		w.read_index = $urandom;
		send_word(w);
	endtask

	task automatic send_read(int idx);
		in_word_t w;
		w = '0;
		w.kind = KIND_READ;
		w.read_index = idx;
		w.start_time = $urandom;
		w.end_time = $urandom;
		w.sample_value = $urandom;
		send_word(w);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_INIT_WIDTH)
			cur_width = (val == 0) ? 1 : val;
		else
			add_enabled = val[0];
	endtask

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$error("Result word arrived with nothing expected");
				fails++;
			end else begin
				e = pending_words.pop_front();
				check_field("status", e.status, out_data.status);
				check_field("start_bin", e.start_bin, out_data.start_bin);
				check_field("bin_span", e.bin_span, out_data.bin_span);
				check_field("fold_count", e.fold_count, out_data.fold_count);
				check_field("bucket_width_now", e.bucket_width_now,
					out_data.bucket_width_now);
				check_field("bin_value", e.bin_value, out_data.bin_value);
				check_field("bin_valid", e.bin_valid, out_data.bin_valid);
				check_field("last_filled_bin", e.last_filled_bin,
					out_data.last_filled_bin);
			end
			stall_left = take_idle ? $urandom_range(0, 12) : 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic test_basic_adds();
		send_read(0);
		send_add(100, 200, 1000);
		send_add(5000, 5000, -1);
		send_add(500, 5000, -7);
		send_add(3000, 20000, 2147483647);
		send_add(9000, 8000, 55);
		for (int i = 0; i < 5; i++)
			send_read(i);
		send_read(19);
	endtask

	task automatic test_saturation();
		write_reg(CFG_INIT_WIDTH, 1);
		send_add(3, 3, 32'h7FFFFFFF);
		send_add(3, 3, 32'h7FFFFFFF);
		send_read(3);
		for (int i = 0; i < 3; i++)
			send_add(4, 4, 32'h80000000);
		send_read(4);
		send_add(1023, 1023, 1);
	endtask

	task automatic test_disabled();
		write_reg(CFG_ENABLED, 0);
		send_add(10, 32'hFFFFFFFF, 99);
		send_add(50, 40, 5);
		send_read(0);
		write_reg(CFG_ENABLED, 1);
	endtask

	task automatic test_full_span();
		write_reg(CFG_INIT_WIDTH, 0);
		send_add(0, 32'hFFFFFFFF, 32'h80000000);
		send_read(0);
		send_read(512);
		send_read(1023);
	endtask

	task automatic test_random_phase(logic [CFG_DATA_W-1:0] width_val, bit en_val, int count);
		longint unsigned lim, st, en, len, tmp;
		int pick;
		write_reg(CFG_INIT_WIDTH, width_val);
		write_reg(CFG_ENABLED, en_val);
		for (int n = 0; n < count; n++) begin
			if ((n % 64) == 0) begin
				send_idle = $urandom_range(0, 3) != 0;
				take_idle = $urandom_range(0, 3) != 0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				send_read($urandom_range(0, 1023));
			end else if (pick < 28) begin
				send_add($urandom, $urandom, $urandom);
			end else begin
				lim = cur_width * NUM_BINS;
				if (lim > 64'hFFFFFFFF) lim = 64'h100000000;
				st = {$urandom, $urandom} % lim;
				if (pick < 75)
					len = $urandom_range(0, 3 * cur_width);
				else
					len = $urandom_range(0, 30 * cur_width);
				en = st + len;
				if (en > 64'hFFFFFFFF) en = 64'hFFFFFFFF;
				if (pick >= 94) begin
					tmp = st;
					st = en;
					en = tmp;
				end
				send_add(st, en, $urandom);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		fails = 0;
		stall_left = 0;
		send_idle = 1'b1;
		take_idle = 1'b1;
		for (int i = 0; i < NUM_BINS; i++) begin
			bin_val[i] = 0;
			bin_ok[i] = 0;
		end
		cur_width = 1024;
		cur_mark = 0;
		add_enabled = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		test_basic_adds();
		test_saturation();
		test_disabled();
		test_full_span();
		test_random_phase(1024, 1, 300);
		test_random_phase(1, 1, 300);
		test_random_phase(23'h7FFFFF, 1, 280);
		test_random_phase(3, 0, 250);
		test_random_phase(0, 1, 280);
		test_random_phase($urandom_range(1, 4194304), 1, 300);
		drain();
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
